FILE: hdl/covs_pkg.sv
// shared types, constants and piece selector table for the outflux volume split
`timescale 1ns / 1ps

package covs_pkg;

    localparam int NUM_PIECES = 26;
    localparam int NUM_FACES  = 6;
    localparam int LEN_W      = 34;
    localparam int OFF_W      = 32;
    localparam int VOL_W      = 48;
    localparam int ACC_W      = 64;
    localparam int ADDR_W     = 4;
    localparam int FIRST_CORNER = 18;

    localparam logic [4:0] LAST_PIECE = 5'(NUM_PIECES - 1);

    // per-axis selector codes
    localparam logic [1:0] SEL_REM  = 2'd0;
    localparam logic [1:0] SEL_HIGH = 2'd1;
    localparam logic [1:0] SEL_LOW  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_SIZE_X    = 2'd1;
    localparam logic [1:0] REG_SIZE_Y    = 2'd2;
    localparam logic [1:0] REG_SIZE_Z    = 2'd3;

    localparam logic [30:0] SIZE_RESET = 31'd65536;

    typedef struct packed {
        logic [31:0] time_step;
        logic [30:0] size_x;
        logic [30:0] size_y;
        logic [30:0] size_z;
    } t_cfg;

    // one classified cell, as handed from front to back
    typedef struct packed {
        logic [2:0][2:0][LEN_W-1:0] len;
        logic [2:0][2:0][OFF_W-1:0] off;
    } t_cell_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // selector per axis {x, y, z} for each piece
    function automatic logic [5:0] piece_sel(input logic [4:0] k);
        logic [5:0] s;
        case (k)
            5'd0:  s = {SEL_REM,  SEL_HIGH, SEL_REM };
            5'd1:  s = {SEL_REM,  SEL_LOW,  SEL_REM };
            5'd2:  s = {SEL_HIGH, SEL_REM,  SEL_REM };
            5'd3:  s = {SEL_LOW,  SEL_REM,  SEL_REM };
            5'd4:  s = {SEL_REM,  SEL_REM,  SEL_HIGH};
            5'd5:  s = {SEL_REM,  SEL_REM,  SEL_LOW };
            5'd6:  s = {SEL_HIGH, SEL_HIGH, SEL_REM };
            5'd7:  s = {SEL_REM,  SEL_HIGH, SEL_HIGH};
            5'd8:  s = {SEL_LOW,  SEL_HIGH, SEL_REM };
            5'd9:  s = {SEL_REM,  SEL_HIGH, SEL_LOW };
            5'd10: s = {SEL_HIGH, SEL_LOW,  SEL_REM };
            5'd11: s = {SEL_REM,  SEL_LOW,  SEL_HIGH};
            5'd12: s = {SEL_LOW,  SEL_LOW,  SEL_REM };
            5'd13: s = {SEL_REM,  SEL_LOW,  SEL_LOW };
            5'd14: s = {SEL_HIGH, SEL_REM,  SEL_LOW };
            5'd15: s = {SEL_HIGH, SEL_REM,  SEL_HIGH};
            5'd16: s = {SEL_LOW,  SEL_REM,  SEL_LOW };
            5'd17: s = {SEL_LOW,  SEL_REM,  SEL_HIGH};
            5'd18: s = {SEL_HIGH, SEL_HIGH, SEL_LOW };
            5'd19: s = {SEL_HIGH, SEL_HIGH, SEL_HIGH};
            5'd20: s = {SEL_LOW,  SEL_HIGH, SEL_LOW };
            5'd21: s = {SEL_LOW,  SEL_HIGH, SEL_HIGH};
            5'd22: s = {SEL_HIGH, SEL_LOW,  SEL_LOW };
            5'd23: s = {SEL_HIGH, SEL_LOW,  SEL_HIGH};
            5'd24: s = {SEL_LOW,  SEL_LOW,  SEL_LOW };
            5'd25: s = {SEL_LOW,  SEL_LOW,  SEL_HIGH};
            default: s = {SEL_REM, SEL_REM, SEL_REM};
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/covs_cell_if.sv
// input channel: six face velocities of one cell
`timescale 1ns / 1ps

interface covs_cell_if;
    logic        valid;
    logic        ready;
    logic [31:0] vel_low_x;
    logic [31:0] vel_high_x;
    logic [31:0] vel_low_y;
    logic [31:0] vel_high_y;
    logic [31:0] vel_low_z;
    logic [31:0] vel_high_z;

    modport source (output valid, vel_low_x, vel_high_x, vel_low_y, vel_high_y,
                    vel_low_z, vel_high_z, input ready);
    modport sink   (input valid, vel_low_x, vel_high_x, vel_low_y, vel_high_y,
                    vel_low_z, vel_high_z, output ready);
endinterface

FILE: hdl/covs_piece_if.sv
// output channel: one outflux piece
`timescale 1ns / 1ps

interface covs_piece_if;
    logic        valid;
    logic        ready;
    logic [4:0]  piece_index;
    logic [47:0] out_volume;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] offset_z;
    logic        over_volume;
    logic        last_piece;

    modport source (output valid, piece_index, out_volume, offset_x, offset_y, offset_z,
                    over_volume, last_piece, input ready);
    modport sink   (input valid, piece_index, out_volume, offset_x, offset_y, offset_z,
                    over_volume, last_piece, output ready);
endinterface

FILE: hdl/covs_vol3.sv
// three-stage triple product of signed lengths, rounded to q32.32 and clamped
`timescale 1ns / 1ps

module covs_vol3
    import covs_pkg::*;
#(
    parameter int CAP_LOG2 = 56
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [LEN_W-1:0] i_a,
    input  logic signed [LEN_W-1:0] i_b,
    input  logic signed [LEN_W-1:0] i_c,
    output logic signed [ACC_W-1:0] o_vol
);

    localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << CAP_LOG2;

    logic [LEN_W-1:0] w_ma, w_mb, w_mc;
    logic [63:0] r_x, r_hi, r_lo;
    logic [31:0] r_mc;
    logic        r_neg1, r_neg2;
    logic [63:0] w_t;
    logic signed [ACC_W-1:0] r_vol;

    // magnitudes, all below 2^32
    assign w_ma = i_a[LEN_W-1] ? -i_a : i_a;
    assign w_mb = i_b[LEN_W-1] ? -i_b : i_b;
    assign w_mc = i_c[LEN_W-1] ? -i_c : i_c;

    // rounding and clamp of the final product
    always_comb begin
        if (r_hi[63:46] != '0) begin
            w_t = CAP;
        end else begin
            w_t = {r_hi[45:0], 16'b0} + {16'b0, r_lo[63:16]} + {63'b0, r_lo[15]};
            if (w_t > CAP) begin
                w_t = CAP;
            end
        end
    end

    // product stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= w_ma[31:0] * w_mb[31:0];
            r_mc   <= w_mc[31:0];
            r_neg1 <= i_a[LEN_W-1] ^ i_b[LEN_W-1] ^ i_c[LEN_W-1];
            r_hi   <= {32'b0, r_x[63:32]} * {32'b0, r_mc};
            r_lo   <= {32'b0, r_x[31:0]} * {32'b0, r_mc};
            r_neg2 <= r_neg1;
            r_vol  <= r_neg2 ? -$signed(w_t) : $signed(w_t);
        end
    end

    assign o_vol = r_vol;

endmodule

FILE: hdl/covs_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps

module covs_queue
    import covs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cell_entry i_data,
    input  logic        i_pop,
    output t_cell_entry o_head,
    output t_q_stat     o_stat
);

    t_cell_entry r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

FILE: hdl/covs_front.sv
// front: takes a cell word, finds face moves and remaining lengths
`timescale 1ns / 1ps

module covs_front
    import covs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    covs_cell_if.sink    i_cell,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_cell_entry  o_entry
);

    logic [31:0] r_vel [NUM_FACES];
    logic        r_busy;
    logic [2:0]  r_cnt;
    logic        r_pv;
    logic [2:0]  r_pidx;
    logic signed [64:0] r_prod;
    logic [30:0] r_move [NUM_FACES];
    logic [64:0] w_d;
    logic [48:0] w_rnd;
    logic [30:0] w_move;
    logic [30:0] w_size [3];

    assign i_cell.ready = !r_busy;
    assign o_push = r_busy && (r_cnt == 3'(NUM_FACES)) && !r_pv && !i_q_stat.full;

    // outward move of one face, rounded and saturated
    always_comb begin
        if (r_pidx[0] == 1'b0) begin
            w_d = r_prod[64] ? 65'(-r_prod) : '0;
        end else begin
            w_d = (!r_prod[64] && r_prod != '0) ? 65'(r_prod) : '0;
        end
        w_rnd  = 49'((w_d + 65'h8000) >> 16);
        w_move = (w_rnd > 49'h7FFFFFFF) ? 31'h7FFFFFFF : w_rnd[30:0];
    end

    // sequencing of the six face products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
        end else begin
            if (i_cell.valid && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (o_push) begin
                r_busy <= 1'b0;
            end
            r_pv <= 1'b0;
            if (r_busy && r_cnt != 3'(NUM_FACES)) begin
                r_cnt <= r_cnt + 3'd1;
                r_pv  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cell.valid && !r_busy) begin
            r_vel[0] <= i_cell.vel_low_x;
            r_vel[1] <= i_cell.vel_high_x;
            r_vel[2] <= i_cell.vel_low_y;
            r_vel[3] <= i_cell.vel_high_y;
            r_vel[4] <= i_cell.vel_low_z;
            r_vel[5] <= i_cell.vel_high_z;
        end
        if (r_busy && r_cnt != 3'(NUM_FACES)) begin
            r_prod <= $signed(r_vel[r_cnt]) * $signed({1'b0, i_cfg.time_step});
            r_pidx <= r_cnt;
        end
        if (r_pv) begin
            r_move[r_pidx] <= w_move;
        end
    end

    assign w_size[0] = i_cfg.size_x;
    assign w_size[1] = i_cfg.size_y;
    assign w_size[2] = i_cfg.size_z;

    // lengths and centroid offsets per axis
    always_comb begin
        logic signed [LEN_W-1:0] sz, hm, lm, t0, t1, t2;
        for (int a = 0; a < 3; a++) begin
            sz = LEN_W'(w_size[a]);
            hm = LEN_W'(r_move[2*a+1]);
            lm = LEN_W'(r_move[2*a]);
            o_entry.len[a][SEL_REM]  = sz - hm - lm;
            o_entry.len[a][SEL_HIGH] = hm;
            o_entry.len[a][SEL_LOW]  = lm;
            t0 = (lm - hm) >>> 1;
            t1 = (sz - hm) >>> 1;
            t2 = (lm - sz) >>> 1;
            o_entry.off[a][SEL_REM]  = t0[OFF_W-1:0];
            o_entry.off[a][SEL_HIGH] = t1[OFF_W-1:0];
            o_entry.off[a][SEL_LOW]  = t2[OFF_W-1:0];
        end
    end

endmodule

FILE: hdl/covs_back.sv
// back: walks 26 pieces per cell through the volume pipe to the output register
`timescale 1ns / 1ps

module covs_back
    import covs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_entry             i_head,
    input  t_q_stat                 i_q_stat,
    input  logic signed [ACC_W-1:0] i_cell_vol,
    output logic                    o_pop,
    covs_piece_if.source            o_piece
);

    localparam logic signed [ACC_W-1:0] VMAX = (ACC_W'(1) << (VOL_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VMIN = -(ACC_W'(1) << (VOL_W - 1));

    logic        w_en, w_issue;
    logic [4:0]  r_k;
    logic [5:0]  w_sel;
    logic [1:0]  w_sx, w_sy, w_sz;
    logic signed [ACC_W-1:0] w_vol, w_sum;
    logic [2:0]  r_sv;
    logic [4:0]  r_sidx [3];
    logic [OFF_W-1:0] r_sox [3], r_soy [3], r_soz [3];
    logic [OFF_W-1:0] w_ox, w_oy, w_oz;
    logic        r_out_valid;
    logic signed [ACC_W-1:0] r_total;
    logic [4:0]  r_idx;
    logic [47:0] r_vol;
    logic [OFF_W-1:0] r_ox, r_oy, r_oz;
    logic        r_over;
    logic        r_last;

    assign w_en    = !r_out_valid || o_piece.ready;
    assign w_issue = w_en && !i_q_stat.empty;
    assign o_pop   = w_issue && (r_k == LAST_PIECE);

    // piece selection
    assign w_sel = piece_sel(r_k);
    assign w_sx  = w_sel[5:4];
    assign w_sy  = w_sel[3:2];
    assign w_sz  = w_sel[1:0];
    assign w_ox  = (r_k < 5'(FIRST_CORNER)) ? i_head.off[0][w_sx] : '0;
    assign w_oy  = (r_k < 5'(FIRST_CORNER)) ? i_head.off[1][w_sy] : '0;
    assign w_oz  = (r_k < 5'(FIRST_CORNER)) ? i_head.off[2][w_sz] : '0;

    covs_vol3 #(.CAP_LOG2(56)) u_vol (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (i_head.len[0][w_sx]),
        .i_b   (i_head.len[1][w_sy]),
        .i_c   (i_head.len[2][w_sz]),
        .o_vol (w_vol)
    );

    // running total over one cell
    assign w_sum = ((r_sidx[2] == '0) ? '0 : r_total) + w_vol;

    // control: piece counter, stage valids, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_sv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            if (w_issue) begin
                r_k <= (r_k == LAST_PIECE) ? '0 : r_k + 5'd1;
            end
            r_sv        <= {r_sv[1:0], w_issue};
            r_out_valid <= r_sv[2];
        end
    end

    // side data alongside the volume pipe and output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sidx[0] <= r_k;
            r_sox[0]  <= w_ox;
            r_soy[0]  <= w_oy;
            r_soz[0]  <= w_oz;
            for (int i = 1; i < 3; i++) begin
                r_sidx[i] <= r_sidx[i-1];
                r_sox[i]  <= r_sox[i-1];
                r_soy[i]  <= r_soy[i-1];
                r_soz[i]  <= r_soz[i-1];
            end
            if (r_sv[2]) begin
                r_total <= w_sum;
                r_idx   <= r_sidx[2];
                r_ox    <= r_sox[2];
                r_oy    <= r_soy[2];
                r_oz    <= r_soz[2];
                r_last  <= (r_sidx[2] == LAST_PIECE);
                r_over  <= (r_sidx[2] == LAST_PIECE) && (w_sum > i_cell_vol);
                if (w_vol > VMAX) begin
                    r_vol <= VMAX[47:0];
                end else if (w_vol < VMIN) begin
                    r_vol <= VMIN[47:0];
                end else begin
                    r_vol <= w_vol[47:0];
                end
            end
        end
    end

    assign o_piece.valid       = r_out_valid;
    assign o_piece.piece_index = r_idx;
    assign o_piece.out_volume  = r_vol;
    assign o_piece.offset_x    = r_ox;
    assign o_piece.offset_y    = r_oy;
    assign o_piece.offset_z    = r_oz;
    assign o_piece.over_volume = r_over;
    assign o_piece.last_piece  = r_last;

`ifndef ASSERT_OFF
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_idx == LAST_PIECE)
        else $error("last flag on wrong piece");
    a_over_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_over |-> r_last)
        else $error("over flag before last piece");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("pop from empty queue");
    a_corner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_idx >= 5'(FIRST_CORNER) |-> r_ox == '0 && r_oy == '0 && r_oz == '0)
        else $error("corner offset not zero");
`endif

endmodule

FILE: hdl/cell_outflux_volume_split.sv
// top level: config registers, front, queue, back and cell volume product
// throughput: one piece word per cycle while the output is ready and the queue holds a cell,
//   set by the single volume product pipe in the back that handles one piece per cycle
// the front runs the six face products of a cell in turn on one shared multiplier; a two-entry queue decouples it
// reset: synchronous active low; clears control state and loads register reset values
`timescale 1ns / 1ps

module cell_outflux_volume_split
    import covs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    covs_cell_if.sink          i_cell,
    covs_piece_if.source       o_piece
);

    t_cfg        r_cfg;
    t_q_stat     w_q_stat;
    t_cell_entry w_entry, w_head;
    logic        w_push, w_pop;
    logic signed [ACC_W-1:0] w_cell_vol;

    assign pready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step <= '0;
            r_cfg.size_x    <= SIZE_RESET;
            r_cfg.size_y    <= SIZE_RESET;
            r_cfg.size_z    <= SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_TIME_STEP: r_cfg.time_step <= pwdata;
                REG_SIZE_X:    r_cfg.size_x    <= pwdata[30:0];
                REG_SIZE_Y:    r_cfg.size_y    <= pwdata[30:0];
                REG_SIZE_Z:    r_cfg.size_z    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_TIME_STEP: prdata = r_cfg.time_step;
            REG_SIZE_X:    prdata = {1'b0, r_cfg.size_x};
            REG_SIZE_Y:    prdata = {1'b0, r_cfg.size_y};
            REG_SIZE_Z:    prdata = {1'b0, r_cfg.size_z};
            default:       prdata = '0;
        endcase
    end

    // cell volume, follows the size registers
    covs_vol3 #(.CAP_LOG2(61)) u_cell_vol (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (LEN_W'(r_cfg.size_x)),
        .i_b   (LEN_W'(r_cfg.size_y)),
        .i_c   (LEN_W'(r_cfg.size_z)),
        .o_vol (w_cell_vol)
    );

    covs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cell   (i_cell),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    covs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    covs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_stat   (w_q_stat),
        .i_cell_vol (w_cell_vol),
        .o_pop      (w_pop),
        .o_piece    (o_piece)
    );

endmodule
